// ===== hw/rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared constants and types of the text console character engine
// Screen geometry, field widths, operation and character codes, and the
// structs that pass between the top level and the cursor unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int CELL_AW = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // Item field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  // Command to the cursor unit
  typedef struct packed {
    logic              put;
    logic              home;
    logic [CHAR_W-1:0] code;
  } tcc_cur_cmd_t;

  // What a put of the presented code would do
  typedef struct packed {
    logic               wr_en;
    logic [CELL_AW-1:0] wr_idx;
    logic [CHAR_W-1:0]  wr_code;
    logic               scroll;
  } tcc_cur_eff_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcc_in_if.sv =====
// ----------------------------------------------------------------------------
// tcc_in_if: request channel of the text console character engine
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if
  import tcc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, output operation, output char_code,
                  output cell_address, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input cell_address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcc_out_if.sv =====
// ----------------------------------------------------------------------------
// tcc_out_if: result channel of the text console character engine
// Valid/ready channel carrying the cursor position and a read cell.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_out_if
  import tcc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_position, output cell_data,
                  input ready);
  modport sink   (input valid, input cursor_position, input cell_data,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcc_cursor.sv =====
// ----------------------------------------------------------------------------
// tcc_cursor: cursor row/column tracking
// Holds the cursor, works out the cell write, wrap and scroll of a put,
// and reports the linear cursor index.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cursor
  import tcc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcc_cur_cmd_t       cmd,
  output      tcc_cur_eff_t       eff,
  output      logic [CELL_AW-1:0] cur_idx
);

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W:0]   col_nxt;
  logic [ROW_W:0]   row_nxt;
  logic [COL_W-1:0] wr_col;

  always_comb begin
    col_nxt     = {1'b0, col_r};
    row_nxt     = {1'b0, row_r};
    wr_col      = col_r;
    eff.wr_en   = 1'b0;
    eff.wr_code = cmd.code;
    case (cmd.code)
      CH_NEWLINE: begin
        col_nxt = '0;
        row_nxt = {1'b0, row_r} + (ROW_W+1)'(1);
      end
      CH_RETURN: begin
        col_nxt = '0;
      end
      CH_TAB: begin
        col_nxt = ({1'b0, col_r} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
      end
      CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt     = {1'b0, col_r} - (COL_W+1)'(1);
          wr_col      = col_r - COL_W'(1);
          eff.wr_en   = 1'b1;
          eff.wr_code = CH_SPACE;
        end
      end
      default: begin
        col_nxt   = {1'b0, col_r} + (COL_W+1)'(1);
        eff.wr_en = 1'b1;
      end
    endcase
    // wrap past the last column
    if (32'(col_nxt) >= 32'(COLUMNS)) begin
      col_nxt = '0;
      row_nxt = row_nxt + (ROW_W+1)'(1);
    end
    // fall off the bottom: scroll and pin to the last row
    eff.scroll = (32'(row_nxt) >= 32'(ROWS));
    if (eff.scroll) begin
      row_nxt = (ROW_W+1)'(ROWS - 1);
    end
    eff.wr_idx = CELL_AW'(row_r) * CELL_AW'(COLUMNS) + CELL_AW'(wr_col);
  end

  assign cur_idx = CELL_AW'(row_r) * CELL_AW'(COLUMNS) + CELL_AW'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.home) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.put) begin
      col_r <= col_nxt[COL_W-1:0];
      row_r <= row_nxt[ROW_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_char_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine: text-mode console character engine
// Cell store of ROWS x COLUMNS 16-bit cells (attribute high, character low)
// with a cursor; puts, reads and clears arrive as items, each answered by one
// result carrying the cursor position.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-----------------------------------
//  in_if    | sink      | valid / ready     | operation, char_code, cell_address
//  out_if   | source    | valid / ready     | cursor_position, cell_data
//  cfg      | sink      | cfg_we (no stall) | cfg_wdata = attribute
//
//  Order: a put, read or undefined item is accepted, then its result is
//    loaded in S_FIN. A put that scrolls first blanks the new bottom row in
//    S_SWEEP; a clear first blanks the whole store. Both sweeps use the
//    single write port of the cell memory, one cell per cycle.
//  Reset: rst_n is synchronous. After reset the store is swept to 0x0720
//    with in_if.ready low; cfg writes are taken meanwhile.
//  Stalls: the result sits in an output register, so a new item is taken
//    while it waits; only the result load waits on out_if.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine
  import tcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  tcc_in_if.sink                 in_if,
  tcc_out_if.source              out_if,
  input  wire logic              cfg_we,
  input  wire logic [ATTR_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_FIN
  } state_t;

  // Scrolling rotates the store: physical = (logical + base) mod CELLS, with
  // base a multiple of COLUMNS. A scroll moves base by one row and blanks the
  // row that wrapped around to the bottom.
  function automatic logic [CELL_AW-1:0] phys_idx(input logic [CELL_AW-1:0] lidx,
                                                  input logic [CELL_AW-1:0] base);
    logic [CELL_AW:0] sum;
    sum = {1'b0, lidx} + {1'b0, base};
    if (32'(sum) >= 32'(CELLS)) begin
      sum = sum - (CELL_AW+1)'(CELLS);
    end
    return sum[CELL_AW-1:0];
  endfunction

  state_t              state_r;
  logic [CELL_AW-1:0]  base_r;
  logic [CELL_AW-1:0]  sw_addr_r;
  logic [CELL_AW-1:0]  sw_end_r;
  logic [CELL_W-1:0]   sw_cell_r;
  logic                sw_res_r;
  logic                pend_rd_r;
  logic                out_valid_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [CELL_W-1:0]   out_data_r;
  logic [ATTR_W-1:0]   attr_r;
  logic [CELL_W-1:0]   mem_q_r;

  logic [CELL_W-1:0]   cell_mem [CELLS];

  logic                in_ready;
  logic                accept;
  logic                rd_ok;
  logic                mem_we;
  logic [CELL_AW-1:0]  mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [CELL_AW-1:0]  mem_raddr;
  logic [CELL_AW-1:0]  base_adv;
  logic                out_free;

  tcc_cur_cmd_t        cur_cmd;
  tcc_cur_eff_t        cur_eff;
  logic [CELL_AW-1:0]  cur_idx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_if.valid && in_ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready            = in_ready;
  assign out_if.valid           = out_valid_r;
  assign out_if.cursor_position = out_pos_r;
  assign out_if.cell_data       = out_data_r;

  // cursor unit: advance on an accepted put, home on an accepted clear
  assign cur_cmd.put  = accept && (in_if.operation == OP_PUT);
  assign cur_cmd.home = accept && (in_if.operation == OP_CLEAR);
  assign cur_cmd.code = in_if.char_code;

  tcc_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cur_cmd),
    .eff     (cur_eff),
    .cur_idx (cur_idx)
  );

  assign base_adv = (base_r == CELL_AW'(CELLS - COLUMNS)) ? '0
                                                          : base_r + CELL_AW'(COLUMNS);

  assign rd_ok     = (32'(in_if.cell_address) < 32'(CELLS));
  assign mem_re    = accept && (in_if.operation == OP_READ) && rd_ok;
  assign mem_raddr = phys_idx(CELL_AW'(in_if.cell_address), base_r);

  // Write port: the sweep owns it in S_SWEEP, a put owns it at accept.
  // Items run one at a time, so a read never overlaps a write in flight.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sw_addr_r;
    mem_wdata = sw_cell_r;
    if (state_r == S_SWEEP) begin
      mem_we = 1'b1;
    end else if (cur_cmd.put && cur_eff.wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = phys_idx(cur_eff.wr_idx, base_r);
      mem_wdata = {attr_r, cur_eff.wr_code};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= cell_mem[mem_raddr];
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      base_r      <= '0;
      sw_addr_r   <= '0;
      sw_end_r    <= CELL_AW'(CELLS - 1);
      sw_cell_r   <= CELL_RESET;
      sw_res_r    <= 1'b0;
      pend_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; a load below overrides
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pend_rd_r <= 1'b0;
            state_r   <= S_FIN;
            case (in_if.operation)
              OP_PUT: begin
                if (cur_eff.scroll) begin
                  // old top row becomes the new bottom row
                  base_r    <= base_adv;
                  sw_addr_r <= base_r;
                  sw_end_r  <= base_r + CELL_AW'(COLUMNS - 1);
                  sw_cell_r <= {attr_r, CH_SPACE};
                  sw_res_r  <= 1'b1;
                  state_r   <= S_SWEEP;
                end
              end
              OP_READ: begin
                pend_rd_r <= rd_ok;
              end
              OP_CLEAR: begin
                base_r    <= '0;
                sw_addr_r <= '0;
                sw_end_r  <= CELL_AW'(CELLS - 1);
                sw_cell_r <= {attr_r, CH_SPACE};
                sw_res_r  <= 1'b1;
                state_r   <= S_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (sw_addr_r == sw_end_r) begin
            state_r <= sw_res_r ? S_FIN : S_IDLE;
          end else begin
            sw_addr_r <= sw_addr_r + CELL_AW'(1);
          end
        end
        S_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= POS_W'(cur_idx);
            out_data_r  <= pend_rd_r ? mem_q_r : '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_if.operation == OP_CLEAR)) |=> (state_r == S_SWEEP))
    else $error("clear item did not start a sweep");

  a_no_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !mem_we)
    else $error("cell memory written while loading a result");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the finish state");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (sw_addr_r <= sw_end_r))
    else $error("sweep ran past its last cell");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_idx) < 32'(CELLS))
    else $error("cursor index outside the store");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console character engine
// Streams put, read, clear and undefined items into the engine while both
// channels idle at random, mirrors the cell store and cursor in a local
// screen model, and checks the cursor position and read cell of every result
// in order. The attribute register is rewritten between phases while idle.
// ----------------------------------------------------------------------------

module tb_top;
  import tcc_pkg::*;

  // Op 3 has no meaning; the engine reports the cursor only.
  localparam logic [OP_W-1:0]   OP_UNDEFINED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_LETTER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_DELETE    = 8'h7F;

  localparam int IDLE_PERCENT  = 26;
  localparam int PHASE_ITEMS   = 120;
  localparam int SETTLE_CYCLES = CELLS + 16;   // a clear walks every cell

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] code;
    logic [ADDR_W-1:0] addr;
  } console_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
  } console_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  text_console_char_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Screen model: logical cell order, row 0 at the top.
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] attr_value;

  console_item_t   pending_items [$];
  console_result_t expected_results [$];
  int              counted_items;
  int              mismatch_count;
  bit              steady_flow;     // suppress idling on both channels

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Worst case is every item a full clear plus stalls; this is far beyond it.
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Screen model: apply one accepted item, return the result it must produce
  // --------------------------------------------------------------------------
  function automatic console_result_t console_apply(console_item_t it);
    console_result_t res;
    int              idx;
    res.cell_val = '0;
    case (it.op)
      OP_PUT: begin
        if (it.code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (it.code == CH_RETURN) begin
          cur_col = 0;
        end else if (it.code == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (it.code == CH_BACKSPACE) begin
          // Backspace at the left edge does nothing at all.
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row * COLUMNS + cur_col] = {attr_value, CH_SPACE};
          end
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {attr_value, it.code};
          cur_col++;
        end
        // Wrap past the last column, scroll past the last row.
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (idx = 0; idx < CELLS - COLUMNS; idx++)
            screen[idx] = screen[idx + COLUMNS];
          for (idx = CELLS - COLUMNS; idx < CELLS; idx++)
            screen[idx] = {attr_value, CH_SPACE};
          cur_row = ROWS - 1;
        end
      end
      OP_READ: begin
        // Out-of-range reads return zero and leave the store alone.
        if (it.addr < CELLS) res.cell_val = screen[it.addr];
      end
      OP_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++)
          screen[idx] = {attr_value, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    res.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: hold valid until accepted, then advance to the next item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    console_item_t next_item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Predict at acceptance; the fields seen here are the ones accepted.
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(console_apply('{in_ch.operation, in_ch.char_code,
                                                   in_ch.cell_address}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_item = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.operation    <= next_item.op;
          in_ch.char_code    <= next_item.code;
          in_ch.cell_address <= next_item.addr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    console_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none, got pos %0d cell %h",
                   $time, out_ch.cursor_position, out_ch.cell_data);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.cursor_position !== want.pos) begin
            mismatch_count++;
            $display("%0t cursor_position mismatch: expected %0d, got %0d",
                     $time, want.pos, out_ch.cursor_position);
          end
          if (out_ch.cell_data !== want.cell_val) begin
            mismatch_count++;
            $display("%0t cell_data mismatch: expected %h, got %h",
                     $time, want.cell_val, out_ch.cell_data);
          end
        end
      end
      out_ch.ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void enqueue(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                                  logic [ADDR_W-1:0] addr);
    pending_items.push_back('{op, code, addr});
    // Ignored items do not count toward a phase.
    if (op != OP_UNDEFINED) counted_items++;
  endfunction

  // Sample at the falling edge so queue and handshake state are settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  // Drain, let any background sweep finish, then load the attribute.
  task automatic load_attribute(input logic [ATTR_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    attr_value  = value;
  endtask

  // Random traffic built from bursts: text lines, newline runs that scroll,
  // control-code mixes, reads, tab runs, the odd clear and raw noise.
  task automatic random_phase(input int target);
    int                first;
    int                kind;
    int                n;
    int                k;
    int                pick;
    logic [ADDR_W-1:0] a;
    logic [CHAR_W-1:0] c;
    first = counted_items;
    while (counted_items - first < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = $urandom_range(1, COLUMNS + 15);
        for (k = 0; k < n; k++)
          enqueue(OP_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)),
                  ADDR_W'($urandom_range(0, 2047)));
        enqueue(OP_PUT, ($urandom_range(0, 9) < 7) ? CH_NEWLINE : CH_RETURN,
                ADDR_W'($urandom_range(0, 2047)));
      end else if (kind < 50) begin
        n = $urandom_range(1, ROWS + 5);
        for (k = 0; k < n; k++)
          enqueue(OP_PUT, CH_NEWLINE, ADDR_W'($urandom_range(0, 2047)));
      end else if (kind < 65) begin
        n = $urandom_range(4, 20);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 4))
            0:       c = CH_BACKSPACE;
            1:       c = CH_TAB;
            2:       c = CH_RETURN;
            3:       c = CH_NEWLINE;
            default: c = CHAR_W'($urandom_range(0, 255));
          endcase
          enqueue(OP_PUT, c, ADDR_W'($urandom_range(0, 2047)));
        end
      end else if (kind < 85) begin
        n = $urandom_range(2, 12);
        for (k = 0; k < n; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 60)      a = ADDR_W'($urandom_range(0, CELLS - 1));
          else if (pick < 75) a = ADDR_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
          else if (pick < 87) a = ADDR_W'($urandom_range(0, 2 * COLUMNS - 1));
          else                a = ADDR_W'($urandom_range(CELLS, 2047));
          enqueue(OP_READ, CHAR_W'($urandom_range(0, 255)), a);
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
          enqueue(OP_PUT, CH_TAB, ADDR_W'($urandom_range(0, 2047)));
      end else if (kind < 94) begin
        enqueue(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                ADDR_W'($urandom_range(0, 2047)));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          enqueue(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                  ADDR_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int k;
    // Drive everything known from time zero; hold reset, then release it.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_PUT;
    in_ch.char_code    = '0;
    in_ch.cell_address = '0;
    out_ch.ready       = 1'b0;
    steady_flow        = 1'b0;
    counted_items      = 0;
    mismatch_count     = 0;
    cur_col            = 0;
    cur_row            = 0;
    attr_value         = ATTR_RESET;
    for (k = 0; k < CELLS; k++) screen[k] = CELL_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, address extremes, every code class, edges.
    enqueue(OP_READ, 8'hFF, '0);
    enqueue(OP_READ, '0, ADDR_W'(CELLS - 1));
    enqueue(OP_READ, '0, '1);
    enqueue(OP_READ, 8'hA5, ADDR_W'(CELLS));
    enqueue(OP_PUT, CH_LETTER_A, '1);
    enqueue(OP_PUT, 8'hFF, '0);
    enqueue(OP_PUT, 8'h80, 11'h555);
    enqueue(OP_PUT, 8'h00, 11'h2AA);
    enqueue(OP_READ, '0, 11'd1);
    enqueue(OP_READ, '0, 11'd3);
    enqueue(OP_PUT, CH_BACKSPACE, '0);
    enqueue(OP_READ, '0, 11'd3);
    enqueue(OP_PUT, CH_TAB, '0);
    enqueue(OP_PUT, CH_RETURN, '0);
    enqueue(OP_PUT, CH_BACKSPACE, '0);
    enqueue(OP_PUT, CH_NEWLINE, '0);
    enqueue(OP_UNDEFINED, 8'hFF, '1);
    enqueue(OP_PUT, CH_DELETE, '0);
    enqueue(OP_READ, '0, ADDR_W'(COLUMNS));
    enqueue(OP_CLEAR, 8'hFF, '1);
    enqueue(OP_READ, '0, '0);
    enqueue(OP_READ, '0, 11'd2);
    enqueue(OP_PUT, CH_SPACE, '0);

    // Random phases, each under a different attribute, extremes included.
    load_attribute(8'h00);
    random_phase(PHASE_ITEMS);
    load_attribute(8'hFF);
    random_phase(PHASE_ITEMS);
    load_attribute(ATTR_W'($urandom_range(0, 255)));
    steady_flow = 1'b1;
    random_phase(PHASE_ITEMS);
    wait_drained();
    steady_flow = 1'b0;
    load_attribute(8'h1E);
    random_phase(PHASE_ITEMS);

    // Drain, then allow a full sweep's worth of cycles for stray results.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
